@@ rtl/frame_presentation_queue_top_macros.svh @@
// Assertion macros for the frame presentation queue checker.
// Both sample on aclk and are off while aresetn is low.
`ifndef FRAME_PRESENTATION_QUEUE_TOP_MACROS_SVH
`define FRAME_PRESENTATION_QUEUE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define FPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define FPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fpq_pkg.sv @@
package fpq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;

    // field widths
    localparam int HANDLE_W = 16;
    localparam int PTS_W    = 33;
    localparam int TIME_W   = 32;
    localparam int REQ_W    = 2;
    localparam int KIND_W   = 2;

    // register widths
    localparam int QLIM_W    = 4;
    localparam int THR_W     = 24;
    localparam int EARLY_W   = 20;
    localparam int LIM_CMP_W = (CNT_W > QLIM_W) ? CNT_W : QLIM_W;

    // arithmetic widths: offset*100+4 needs 7 more bits than a timestamp
    localparam int OFF_W     = PTS_W + 1;
    localparam int DIV_W     = PTS_W + 7;
    localparam int REM_W     = 4;
    localparam int US_W      = TIME_W + 12;

    // divide by 9 in radix-1024 steps; DIV_W is a whole number of steps
    localparam int DIV_STEP_W  = 10;
    localparam int DIV_STEPS   = DIV_W / DIV_STEP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int TRIAL_W     = REM_W + DIV_STEP_W;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = TRIAL_W + RECIP_W;

    // stream word layout
    localparam int IN_DATA_W  = ((HANDLE_W + PTS_W + TIME_W + 7) / 8) * 8;
    localparam int HANDLE_LSB = 0;
    localparam int PTS_LSB    = HANDLE_W;
    localparam int TIME_LSB   = HANDLE_W + PTS_W;
    localparam int OUT_DATA_W = ((HANDLE_W + 7) / 8) * 8;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [REQ_W-1:0]      req_t;
    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [APB_ADDR_W-1:0] apb_addr_t;

    // request codes
    localparam req_t REQ_ENQ   = 2'd0;
    localparam req_t REQ_DEQ   = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;

    // result codes
    localparam kind_t KIND_DROP    = 2'd0;
    localparam kind_t KIND_PRESENT = 2'd1;
    localparam kind_t KIND_EMPTY   = 2'd2;
    localparam kind_t KIND_DONE    = 2'd3;

    // register byte addresses
    localparam apb_addr_t ADDR_QLIMIT = 4'h0;
    localparam apb_addr_t ADDR_THR    = 4'h4;
    localparam apb_addr_t ADDR_EARLY  = 4'h8;

    // register reset values
    localparam logic [QLIM_W-1:0]  QLIMIT_RST = 4'd6;
    localparam logic [THR_W-1:0]   THR_RST    = 24'd500000;
    localparam logic [EARLY_W-1:0] EARLY_RST  = 20'd16666;

    // offset rescale: round(off*100/9) = (off*100 + 4) / 9
    // t/9 for t < 9*1024 is (t*3641) >> 15, since 9*3641 = 2^15 + 1
    localparam logic [RECIP_W-1:0] SCALE_RECIP = 12'd3641;
    localparam int                 SCALE_BIAS  = 4;

endpackage

@@ rtl/frame_presentation_queue_top.sv @@
// Enqueue: write the frame, then drop oldest frames while at the limit, else
// send a done word. Dequeue: time setup, then per frame examined: pop, times
// 100, four radix-1024 steps of the divide by 9, difference, decision, plus a
// done word when every frame is dropped. Clear, no-op, empty dequeue: one word.
// One request in flight at a time; stalls on the result hold it. Reset (aresetn
// low, synchronous) empties the queue, drops the base, restores the registers.
module frame_presentation_queue_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] frame_handle, [48:16] frame_pts, [80:49] current_time_ms
    input  logic [fpq_pkg::IN_DATA_W-1:0]         s_tdata,
    // [1:0] req_type
    input  logic [fpq_pkg::REQ_W-1:0]             s_tuser,
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] out_handle
    output logic [fpq_pkg::OUT_DATA_W-1:0]        m_tdata,
    // [1:0] result_kind
    output logic [fpq_pkg::KIND_W-1:0]            m_tuser,
    output logic                                  m_tlast,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fpq_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [fpq_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [fpq_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ENQ_RD = 4'd1;
    localparam logic [3:0] ST_ENQ    = 4'd2;
    localparam logic [3:0] ST_SINGLE = 4'd3;
    localparam logic [3:0] ST_TIME   = 4'd4;
    localparam logic [3:0] ST_POP    = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DIFF   = 4'd8;
    localparam logic [3:0] ST_DECIDE = 4'd9;

    localparam int IDX_W   = fpq_pkg::IDX_W;
    localparam int CNT_W   = fpq_pkg::CNT_W;
    localparam int PTS_W   = fpq_pkg::PTS_W;
    localparam int HW      = fpq_pkg::HANDLE_W;
    localparam int TIME_W  = fpq_pkg::TIME_W;
    localparam int US_W    = fpq_pkg::US_W;
    localparam int DIV_W   = fpq_pkg::DIV_W;
    localparam int REM_W   = fpq_pkg::REM_W;
    localparam int OFF_W   = fpq_pkg::OFF_W;
    localparam int LCMP_W  = fpq_pkg::LIM_CMP_W;
    localparam int DCNT_W  = fpq_pkg::DIV_CNT_W;
    localparam int DSTEP_W = fpq_pkg::DIV_STEP_W;
    localparam int TRIAL_W = fpq_pkg::TRIAL_W;
    localparam int PROD_W  = fpq_pkg::PROD_W;

    // control and datapath registers
    logic [3:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                head_reg, head_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [PTS_W-1:0]                base_reg, base_next;
    logic                            base_valid_reg, base_valid_next;
    logic [TIME_W-1:0]               timer_reg, timer_next;
    logic [TIME_W-1:0]               now_ms_reg, now_ms_next;
    logic [US_W-1:0]                 now_us_reg, now_us_next;
    fpq_pkg::kind_t                  kind_reg, kind_next;
    logic [PTS_W-1:0]                p_reg, p_next;
    logic [HW-1:0]                   h_reg, h_next;
    logic                            neg_reg, neg_next;
    logic [PTS_W-1:0]                mag_reg, mag_next;
    logic [DIV_W-1:0]                quot_reg, quot_next;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [DCNT_W-1:0]               dcnt_reg, dcnt_next;
    logic signed [US_W-1:0]          diff_reg, diff_next;

    // configuration registers
    logic [fpq_pkg::QLIM_W-1:0]      qlim_reg, qlim_next;
    logic [fpq_pkg::THR_W-1:0]       thr_reg, thr_next;
    logic [fpq_pkg::EARLY_W-1:0]     early_reg, early_next;

    // output word register
    logic                            m_valid_reg, m_valid_next;
    fpq_pkg::kind_t                  m_kind_reg, m_kind_next;
    logic [HW-1:0]                   m_hdl_reg, m_hdl_next;
    logic                            m_last_reg, m_last_next;

    // frame store
    logic [PTS_W-1:0]                pts_mem [fpq_pkg::QUEUE_DEPTH];
    logic [HW-1:0]                   hdl_mem [fpq_pkg::QUEUE_DEPTH];
    logic [PTS_W-1:0]                rd_pts_reg;
    logic [HW-1:0]                   rd_hdl_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                tail_idx;
    logic [fpq_pkg::SUM_W-1:0]       tail_sum;

    // combinational helpers
    logic                            s_accept;
    logic                            out_free;
    logic                            emit_en;
    fpq_pkg::kind_t                  emit_kind;
    logic [HW-1:0]                   emit_hdl;
    logic                            emit_last;
    logic [IDX_W-1:0]                head_inc;
    logic [CNT_W-1:0]                cnt_dec;
    logic [LCMP_W-1:0]               lim;
    logic                            cnt_at_lim;
    logic                            dec_at_lim;
    logic [TIME_W-1:0]               elapsed_ms;
    logic [US_W-1:0]                 elapsed_us;
    logic [OFF_W-1:0]                off;
    logic [OFF_W-1:0]                neg_off;
    logic [DIV_W-1:0]                mag_ext;
    logic [TRIAL_W-1:0]              trial;
    logic [PROD_W-1:0]               recip_prod;
    logic [DSTEP_W-1:0]              div_digit;
    logic [TRIAL_W-1:0]              div_back;
    logic [US_W-1:0]                 q_ext;
    logic [US_W-1:0]                 scaled;
    logic [US_W-1:0]                 abs_diff;
    logic                            resync;
    logic                            due;
    logic                            cfg_wr;

    logic [HW-1:0]                   in_handle;
    logic [PTS_W-1:0]                in_pts;
    logic [TIME_W-1:0]               in_time;

    assign in_handle = s_tdata[fpq_pkg::HANDLE_LSB +: HW];
    assign in_pts    = s_tdata[fpq_pkg::PTS_LSB +: PTS_W];
    assign in_time   = s_tdata[fpq_pkg::TIME_LSB +: TIME_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = fpq_pkg::OUT_DATA_W'(m_hdl_reg);
    assign m_tlast  = m_last_reg;

    // ring pointer arithmetic
    assign head_inc = (head_reg == IDX_W'(fpq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;
    assign tail_sum = fpq_pkg::SUM_W'(head_reg) + fpq_pkg::SUM_W'(cnt_reg);
    assign tail_idx = (tail_sum >= fpq_pkg::SUM_W'(fpq_pkg::QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - fpq_pkg::SUM_W'(fpq_pkg::QUEUE_DEPTH))
                    : IDX_W'(tail_sum);

    // effective limit, clamped to the depth
    assign lim = (LCMP_W'(qlim_reg) > LCMP_W'(fpq_pkg::QUEUE_DEPTH))
               ? LCMP_W'(fpq_pkg::QUEUE_DEPTH) : LCMP_W'(qlim_reg);
    assign cnt_at_lim = (cnt_reg != '0) && (LCMP_W'(cnt_reg) >= lim);
    assign dec_at_lim = (cnt_dec != '0) && (LCMP_W'(cnt_dec) >= lim);

    // elapsed ms -> us as x*1024 - x*16 - x*8
    assign elapsed_ms = base_valid_reg ? (now_ms_reg - timer_reg) : '0;
    assign elapsed_us = (US_W'(elapsed_ms) << 10) - (US_W'(elapsed_ms) << 4)
                      - (US_W'(elapsed_ms) << 3);

    // signed offset from the base and its negation
    assign off     = {1'b0, rd_pts_reg} - {1'b0, base_reg};
    assign neg_off = -off;

    // dividend: mag*100 + 4 as mag*64 + mag*32 + mag*4 + 4
    assign mag_ext = DIV_W'(mag_reg);

    // one radix-1024 step of the divide by 9: remainder joined with the next
    // ten dividend bits, digit by reciprocal multiply, new remainder
    assign trial      = {rem_reg, quot_reg[DIV_W-1 -: DSTEP_W]};
    assign recip_prod = PROD_W'(trial) * PROD_W'(fpq_pkg::SCALE_RECIP);
    assign div_digit  = recip_prod[fpq_pkg::RECIP_SHIFT +: DSTEP_W];
    assign div_back   = (TRIAL_W'(div_digit) << 3) + TRIAL_W'(div_digit);

    // signed rescaled offset
    assign q_ext  = US_W'(quot_reg);
    assign scaled = neg_reg ? (-q_ext) : q_ext;

    // drift and due tests
    assign abs_diff = diff_reg[US_W-1] ? US_W'(-diff_reg) : US_W'(diff_reg);
    assign resync   = (abs_diff >= US_W'(thr_reg));
    assign due      = (diff_reg <= $signed(US_W'(early_reg)));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        base_valid_next = base_valid_reg;
        timer_next      = timer_reg;
        now_ms_next     = now_ms_reg;
        now_us_next     = now_us_reg;
        kind_next       = kind_reg;
        p_next          = p_reg;
        h_next          = h_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        diff_next       = diff_reg;
        mem_we          = 1'b0;
        emit_en         = 1'b0;
        emit_kind       = fpq_pkg::KIND_DONE;
        emit_hdl        = '0;
        emit_last       = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        fpq_pkg::REQ_ENQ: begin
                            mem_we     = 1'b1;
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = ST_ENQ_RD;
                        end
                        fpq_pkg::REQ_DEQ: begin
                            if (cnt_reg == '0) begin
                                kind_next  = fpq_pkg::KIND_EMPTY;
                                state_next = ST_SINGLE;
                            end else begin
                                now_ms_next = in_time;
                                state_next  = ST_TIME;
                            end
                        end
                        fpq_pkg::REQ_CLEAR: begin
                            head_next  = '0;
                            cnt_next   = '0;
                            kind_next  = fpq_pkg::KIND_DONE;
                            state_next = ST_SINGLE;
                        end
                        default: begin
                            kind_next  = fpq_pkg::KIND_DONE;
                            state_next = ST_SINGLE;
                        end
                    endcase
                end
            end

            // let the read port see the word just written
            ST_ENQ_RD: begin
                state_next = ST_ENQ;
            end

            // drop oldest frames while at the limit, else report done
            ST_ENQ: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    if (cnt_at_lim) begin
                        emit_kind = fpq_pkg::KIND_DROP;
                        emit_hdl  = rd_hdl_reg;
                        emit_last = !dec_at_lim;
                        head_next = head_inc;
                        cnt_next  = cnt_dec;
                        if (!dec_at_lim) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SINGLE: begin
                if (out_free) begin
                    emit_en    = 1'b1;
                    emit_kind  = kind_reg;
                    state_next = ST_IDLE;
                end
            end

            // latch base on first use, then elapsed time in us
            ST_TIME: begin
                if (!base_valid_reg) begin
                    base_next       = rd_pts_reg;
                    timer_next      = now_ms_reg;
                    base_valid_next = 1'b1;
                end
                now_us_next = elapsed_us;
                state_next  = ST_POP;
            end

            // pop head, form offset sign and magnitude
            ST_POP: begin
                p_next     = rd_pts_reg;
                h_next     = rd_hdl_reg;
                neg_next   = off[OFF_W-1];
                mag_next   = off[OFF_W-1] ? neg_off[PTS_W-1:0] : off[PTS_W-1:0];
                head_next  = head_inc;
                cnt_next   = cnt_dec;
                state_next = ST_MUL;
            end

            ST_MUL: begin
                quot_next  = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2)
                           + DIV_W'(fpq_pkg::SCALE_BIAS);
                rem_next   = '0;
                dcnt_next  = DCNT_W'(fpq_pkg::DIV_STEPS);
                state_next = ST_DIV;
            end

            // ten quotient bits per cycle
            ST_DIV: begin
                rem_next  = REM_W'(trial - div_back);
                quot_next = {quot_reg[DIV_W-DSTEP_W-1:0], div_digit};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1)) begin
                    state_next = ST_DIFF;
                end
            end

            ST_DIFF: begin
                diff_next  = $signed(scaled - now_us_reg);
                state_next = ST_DECIDE;
            end

            ST_DECIDE: begin
                if (out_free) begin
                    emit_en  = 1'b1;
                    emit_hdl = h_reg;
                    if (resync) begin
                        base_next   = p_reg;
                        timer_next  = now_ms_reg;
                        now_us_next = '0;
                    end
                    if (resync || due) begin
                        emit_kind = fpq_pkg::KIND_DROP;
                        emit_last = 1'b0;
                        if (cnt_reg == '0) begin
                            kind_next  = fpq_pkg::KIND_DONE;
                            state_next = ST_SINGLE;
                        end else begin
                            state_next = ST_POP;
                        end
                    end else begin
                        emit_kind  = fpq_pkg::KIND_PRESENT;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_hdl_next   = m_hdl_reg;
        m_last_next  = m_last_reg;
        if (emit_en) begin
            m_valid_next = 1'b1;
            m_kind_next  = emit_kind;
            m_hdl_next   = emit_hdl;
            m_last_next  = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // register port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        qlim_next  = qlim_reg;
        thr_next   = thr_reg;
        early_next = early_reg;
        if (cfg_wr) begin
            case (paddr)
                fpq_pkg::ADDR_QLIMIT: qlim_next  = pwdata[fpq_pkg::QLIM_W-1:0];
                fpq_pkg::ADDR_THR:    thr_next   = pwdata[fpq_pkg::THR_W-1:0];
                fpq_pkg::ADDR_EARLY:  early_next = pwdata[fpq_pkg::EARLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            fpq_pkg::ADDR_QLIMIT: prdata = fpq_pkg::APB_DATA_W'(qlim_reg);
            fpq_pkg::ADDR_THR:    prdata = fpq_pkg::APB_DATA_W'(thr_reg);
            fpq_pkg::ADDR_EARLY:  prdata = fpq_pkg::APB_DATA_W'(early_reg);
            default:              prdata = '0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            cnt_reg        <= '0;
            base_reg       <= '0;
            base_valid_reg <= 1'b0;
            timer_reg      <= '0;
            m_valid_reg    <= 1'b0;
            qlim_reg       <= fpq_pkg::QLIMIT_RST;
            thr_reg        <= fpq_pkg::THR_RST;
            early_reg      <= fpq_pkg::EARLY_RST;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            base_reg       <= base_next;
            base_valid_reg <= base_valid_next;
            timer_reg      <= timer_next;
            m_valid_reg    <= m_valid_next;
            qlim_reg       <= qlim_next;
            thr_reg        <= thr_next;
            early_reg      <= early_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        now_ms_reg <= now_ms_next;
        now_us_reg <= now_us_next;
        kind_reg   <= kind_next;
        p_reg      <= p_next;
        h_reg      <= h_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        diff_reg   <= diff_next;
        m_kind_reg <= m_kind_next;
        m_hdl_reg  <= m_hdl_next;
        m_last_reg <= m_last_next;
    end

    // frame store: write at tail, registered read at the next head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pts_mem[tail_idx] <= in_pts;
            hdl_mem[tail_idx] <= in_handle;
        end
        rd_pts_reg <= pts_mem[head_next];
        rd_hdl_reg <= hdl_mem[head_next];
    end

endmodule

@@ rtl/fpq_checker.sv @@
`include "frame_presentation_queue_top_macros.svh"

module fpq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fpq_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [fpq_pkg::KIND_W-1:0]     m_tuser,
    input logic                           m_tlast
);

    // a stalled result word holds
    `FPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

    // one request in flight: busy right after an accept
    `FPQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after a request was taken")

    // when ready again, any pending word closes the previous run
    `FPQ_ASSERT_SAME(a_idle_tail_last, s_tready && m_tvalid, m_tlast, "ready while a run is still open")

    // present and empty always end a run
    `FPQ_ASSERT_SAME(a_terminal_last, m_tvalid && (m_tuser == fpq_pkg::KIND_PRESENT || m_tuser == fpq_pkg::KIND_EMPTY), m_tlast, "present or empty word without tlast")

    // empty and done carry no handle
    `FPQ_ASSERT_SAME(a_no_handle, m_tvalid && (m_tuser == fpq_pkg::KIND_EMPTY || m_tuser == fpq_pkg::KIND_DONE), m_tdata == '0, "status word with nonzero handle")

endmodule

bind frame_presentation_queue_top fpq_checker u_fpq_checker (.*);
